FILE: hdl/ymr_pkg.sv
// Shared types, codes and the CRC-16/XMODEM byte step for the YMODEM receiver.
// No dependencies; used by every module under hdl/.
`default_nettype none

package ymr_pkg;

  localparam logic [10:0] SHORT_BLOCK = 11'd128;
  localparam logic [10:0] LONG_BLOCK  = 11'd1024;
  localparam logic [10:0] CANCEL_LEN  = 11'd2;

  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_CA  = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EOT      = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_ABORT    = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_NUM_BAD  = 3'd5;
  localparam logic [2:0] ST_CRC_BAD  = 3'd6;
  localparam logic [2:0] ST_TIMEOUT  = 3'd7;

  localparam logic CFG_ABORT_A = 1'b0;
  localparam logic CFG_ABORT_B = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_CANCEL = 7'b0000010,
    PH_NUMBER = 7'b0000100,
    PH_COMPL  = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CRC_HI = 7'b0100000,
    PH_CRC_LO = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] code_a;
    logic [7:0] code_b;
  } abort_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [9:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  block_number;
    logic [10:0] block_len;
  } result_t;

  // Plain (non-augmented) CRC-16/XMODEM update, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ymr_cfg.sv
// Abort code registers written through the configuration channel.
// Depends on ymr_pkg.
`default_nettype none

module ymr_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  output ymr_pkg::abort_cfg_t    abort_cfg
);

  ymr_pkg::abort_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign abort_cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.code_a <= 8'd65;
      regs.code_b <= 8'd97;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ymr_pkg::CFG_ABORT_A: regs.code_a <= cfg_data;
        ymr_pkg::CFG_ABORT_B: regs.code_b <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ymr_parser.sv
// Input register, packet phase tracking, CRC and per-beat result decision.
// Depends on ymr_pkg.
`default_nettype none

module ymr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [7:0]           in_byte,
  input  wire ymr_pkg::abort_cfg_t  abort_cfg,
  input  wire logic                 res_ready,
  output logic                      advance,
  output logic                      res_valid,
  output ymr_pkg::result_t          res
);

  logic        item_valid;
  logic        item_action;
  logic [7:0]  item_byte;

  ymr_pkg::phase_t phase, phase_next;
  logic        long_block, long_block_next;
  logic [10:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_number, held_number_next;
  logic        number_bad, number_bad_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic [10:0] size;

  assign advance  = item_valid && res_ready;
  assign in_ready = !item_valid || res_ready;
  assign size     = long_block ? ymr_pkg::LONG_BLOCK : ymr_pkg::SHORT_BLOCK;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_action <= in_action;
      item_byte   <= in_byte;
    end
  end

  always_comb begin
    phase_next         = phase;
    long_block_next    = long_block;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    held_number_next   = held_number;
    number_bad_next    = number_bad;
    crc_high_byte_next = crc_high_byte;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = ymr_pkg::KIND_VERDICT;

    if (item_action == ymr_pkg::ACT_TIMEOUT) begin
      phase_next = ymr_pkg::PH_IDLE;
      res_valid  = 1'b1;
      res.status = ymr_pkg::ST_TIMEOUT;
    end else begin
      unique case (phase)
        ymr_pkg::PH_IDLE: begin
          if (item_byte == ymr_pkg::CODE_SOH || item_byte == ymr_pkg::CODE_STX) begin
            long_block_next  = (item_byte == ymr_pkg::CODE_STX);
            byte_count_next  = '0;
            running_crc_next = '0;
            number_bad_next  = 1'b0;
            phase_next       = ymr_pkg::PH_NUMBER;
          end else if (item_byte == ymr_pkg::CODE_EOT) begin
            res_valid  = 1'b1;
            res.status = ymr_pkg::ST_EOT;
          end else if (item_byte == ymr_pkg::CODE_CA) begin
            phase_next = ymr_pkg::PH_CANCEL;
          end else if (item_byte == abort_cfg.code_a || item_byte == abort_cfg.code_b) begin
            res_valid  = 1'b1;
            res.status = ymr_pkg::ST_ABORT;
          end else begin
            res_valid  = 1'b1;
            res.status = ymr_pkg::ST_BAD;
          end
        end
        ymr_pkg::PH_CANCEL: begin
          phase_next = ymr_pkg::PH_IDLE;
          res_valid  = 1'b1;
          if (item_byte == ymr_pkg::CODE_CA) begin
            res.status    = ymr_pkg::ST_CANCEL;
            res.block_len = ymr_pkg::CANCEL_LEN;
          end else begin
            res.status = ymr_pkg::ST_BAD;
          end
        end
        ymr_pkg::PH_NUMBER: begin
          held_number_next = item_byte;
          phase_next       = ymr_pkg::PH_COMPL;
        end
        ymr_pkg::PH_COMPL: begin
          number_bad_next = (held_number != ~item_byte);
          phase_next      = ymr_pkg::PH_DATA;
        end
        ymr_pkg::PH_DATA: begin
          running_crc_next = ymr_pkg::crc_step(running_crc, item_byte);
          byte_count_next  = byte_count + 11'd1;
          if (byte_count_next >= size) begin
            phase_next = ymr_pkg::PH_CRC_HI;
          end
          res_valid        = 1'b1;
          res.kind         = ymr_pkg::KIND_PAYLOAD;
          res.payload_byte = item_byte;
          res.byte_index   = byte_count[9:0];
          res.block_number = held_number;
        end
        ymr_pkg::PH_CRC_HI: begin
          crc_high_byte_next = item_byte;
          phase_next         = ymr_pkg::PH_CRC_LO;
        end
        ymr_pkg::PH_CRC_LO: begin
          phase_next       = ymr_pkg::PH_IDLE;
          res_valid        = 1'b1;
          res.block_number = held_number;
          if (number_bad) begin
            res.status = ymr_pkg::ST_NUM_BAD;
          end else if (running_crc != {crc_high_byte, item_byte}) begin
            res.status = ymr_pkg::ST_CRC_BAD;
          end else begin
            res.status    = ymr_pkg::ST_OK;
            res.block_len = size;
          end
        end
        default: begin
          phase_next = ymr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ymr_pkg::PH_IDLE;
      long_block    <= 1'b0;
      byte_count    <= '0;
      running_crc   <= '0;
      held_number   <= '0;
      number_bad    <= 1'b0;
      crc_high_byte <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      long_block    <= long_block_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      held_number   <= held_number_next;
      number_bad    <= number_bad_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  // short blocks never run past their length
  assert property (@(posedge clk) disable iff (rst)
    (phase == ymr_pkg::PH_DATA && !long_block) |-> (byte_count < ymr_pkg::SHORT_BLOCK))
    else $error("short block count overrun");

  assert property (@(posedge clk) disable iff (rst)
    (advance && item_action == ymr_pkg::ACT_TIMEOUT) |=> (phase == ymr_pkg::PH_IDLE))
    else $error("timeout did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind == ymr_pkg::KIND_VERDICT && res.status == ymr_pkg::ST_OK)
    |-> (res.block_len == ymr_pkg::SHORT_BLOCK || res.block_len == ymr_pkg::LONG_BLOCK))
    else $error("ok verdict with bad length");

  assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind == ymr_pkg::KIND_PAYLOAD)
    |-> (res.status == ymr_pkg::ST_OK && res.block_len == '0 && phase == ymr_pkg::PH_DATA))
    else $error("payload beat outside data phase");

endmodule

`default_nettype wire

FILE: hdl/ymr_out_reg.sv
// Result register driving the master stream; packs the result fields into tdata.
// Depends on ymr_pkg.
`default_nettype none

module ymr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              load_valid,
  input  wire ymr_pkg::result_t  load_res,
  output logic                   take_ready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [39:0]            m_tdata,
  output logic                   m_tuser
);

  logic             out_valid;
  ymr_pkg::result_t out_res;

  assign take_ready = !out_valid || m_tready;
  assign m_tvalid   = out_valid;
  assign m_tuser    = out_res.kind;
  assign m_tdata    = {out_res.block_len, out_res.block_number, out_res.status,
                       out_res.byte_index, out_res.payload_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ymodem_packet_receiver.sv
// YMODEM packet receiver with CRC-16/XMODEM check, one serial event per beat.
// A result passes the input register and then the result register on its way out.
// Throughput: one input beat per cycle unless a full result register is held by m_tready; s_tready follows it.
// Reset (rst, synchronous): back to idle, counters and CRC cleared, abort codes 65 and 97.
// Depends on ymr_pkg, ymr_cfg, ymr_parser, ymr_out_reg.
`default_nettype none

module ymodem_packet_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] payload_byte, [17:8] byte_index, [20:18] status,
                                      // [28:21] block_number, [39:29] block_len
  output logic             m_tuser,   // [0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  ymr_pkg::abort_cfg_t abort_cfg;
  ymr_pkg::result_t    res;
  logic                res_valid;
  logic                advance;
  logic                take_ready;

  ymr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .abort_cfg (abort_cfg)
  );

  ymr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_byte   (s_tdata),
    .abort_cfg (abort_cfg),
    .res_ready (take_ready),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  ymr_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .load_valid (res_valid),
    .load_res   (res),
    .take_ready (take_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

FILE: bench/ymr_stream_checker.sv
// Scoreboard for the YMODEM packet receiver: watches the input, output and register
// streams, predicts every result beat and compares it with what the block sends.
// Depends on ymr_pkg for codes, phases and the result layout.
`timescale 1ns / 100ps

module ymr_stream_checker
  import ymr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          waiting
);

  // receiver state as seen from outside
  phase_t      ph;
  logic        is_long;
  logic [10:0] count;
  logic [15:0] crc;
  logic [7:0]  num;
  logic        num_bad;
  logic [7:0]  crc_hi;
  abort_cfg_t  codes;

  result_t     results_due[$];

  initial begin
    errors  = 0;
    waiting = 0;
  end

  // CRC-16/XMODEM, one byte MSB first
  function automatic logic [15:0] crc_after_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic clear_receiver();
    ph           = PH_IDLE;
    is_long      = 1'b0;
    count        = '0;
    crc          = '0;
    num          = '0;
    num_bad      = 1'b0;
    crc_hi       = '0;
    codes.code_a = 8'd65;
    codes.code_b = 8'd97;
    results_due.delete();
  endtask

  task automatic decode_event(input logic act, input logic [7:0] b);
    result_t     r;
    logic        emit;
    logic [10:0] size;
    r    = '0;
    emit = 1'b0;
    size = is_long ? LONG_BLOCK : SHORT_BLOCK;
    if (act == ACT_TIMEOUT) begin
      ph       = PH_IDLE;
      emit     = 1'b1;
      r.kind   = KIND_VERDICT;
      r.status = ST_TIMEOUT;
    end else begin
      case (ph)
        PH_IDLE: begin
          if (b == CODE_SOH || b == CODE_STX) begin
            is_long = (b == CODE_STX);
            count   = '0;
            crc     = '0;
            num_bad = 1'b0;
            ph      = PH_NUMBER;
          end else if (b == CODE_CA) begin
            ph = PH_CANCEL;
          end else begin
            // fixed codes were tested above, so they win over the abort codes
            emit   = 1'b1;
            r.kind = KIND_VERDICT;
            if (b == CODE_EOT)
              r.status = ST_EOT;
            else if (b == codes.code_a || b == codes.code_b)
              r.status = ST_ABORT;
            else
              r.status = ST_BAD;
          end
        end
        PH_CANCEL: begin
          ph     = PH_IDLE;
          emit   = 1'b1;
          r.kind = KIND_VERDICT;
          if (b == CODE_CA) begin
            r.status    = ST_CANCEL;
            r.block_len = CANCEL_LEN;
          end else begin
            r.status = ST_BAD;
          end
        end
        PH_NUMBER: begin
          num = b;
          ph  = PH_COMPL;
        end
        PH_COMPL: begin
          num_bad = (num != ~b);
          ph      = PH_DATA;
        end
        PH_DATA: begin
          emit           = 1'b1;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          r.byte_index   = count[9:0];
          r.block_number = num;
          crc            = crc_after_byte(crc, b);
          count          = count + 11'd1;
          if (count >= size)
            ph = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_hi = b;
          ph     = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          ph             = PH_IDLE;
          emit           = 1'b1;
          r.kind         = KIND_VERDICT;
          r.block_number = num;
          // number mismatch hides a CRC mismatch
          if (num_bad) begin
            r.status = ST_NUM_BAD;
          end else if (crc != {crc_hi, b}) begin
            r.status = ST_CRC_BAD;
          end else begin
            r.status    = ST_OK;
            r.block_len = size;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (emit)
      results_due.push_back(r);
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, got tuser %0d tdata %h",
               $time, m_tuser, m_tdata);
    end else begin
      want = results_due.pop_front();
      cmp_field("kind", want.kind, m_tuser);
      cmp_field("payload_byte", want.payload_byte, m_tdata[7:0]);
      cmp_field("byte_index", want.byte_index, m_tdata[17:8]);
      cmp_field("status", want.status, m_tdata[20:18]);
      cmp_field("block_number", want.block_number, m_tdata[28:21]);
      cmp_field("block_len", want.block_len, m_tdata[39:29]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_receiver();
    end else begin
      if (m_tvalid && m_tready)
        check_beat();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ABORT_A)
          codes.code_a = cfg_data;
        else
          codes.code_b = cfg_data;
      end
      if (s_tvalid && s_tready)
        decode_event(s_tuser, s_tdata);
    end
    waiting = results_due.size();
  end

endmodule

FILE: bench/tb_ymodem_packet_receiver.sv
// Top of the YMODEM receiver bench: clock, reset, stimulus and verdict.
// Instantiates ymodem_packet_receiver and ymr_stream_checker; uses ymr_pkg.
`timescale 1ns / 100ps

module tb_ymodem_packet_receiver;
  import ymr_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int          errors;
  int          waiting;
  int          n_sent;
  int          quiet;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic [7:0]  code_a;
  logic [7:0]  code_b;

  ymodem_packet_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ymr_stream_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure
  always @(negedge clk)
    m_tready = ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] crc16_xmodem(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // called and returns at a falling edge; tvalid stays high into the next beat
  task automatic push_event(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom_range(255));
      s_tuser  = 1'($urandom_range(1));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (waiting != 0) @(negedge clk);
    // a beat that gives no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_codes(input logic [7:0] a, input logic [7:0] b);
    drain();
    for (int r = 0; r < 2; r++) begin
      cfg_valid = 1'b1;
      cfg_index = r ? CFG_ABORT_B : CFG_ABORT_A;
      cfg_data  = r ? b : a;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    code_a    = a;
    code_b    = b;
  endtask

  // full block; cut >= 0 replaces the beat at that position by a timeout and ends the block there
  task automatic send_block(input bit big, input logic [7:0] num, input bit num_ok,
                            input bit crc_ok, input int cut);
    logic [15:0] c;
    logic [15:0] flip;
    logic [7:0]  d;
    int          len;
    len  = big ? 1024 : 128;
    c    = '0;
    flip = crc_ok ? 16'h0000 : 16'($urandom_range(16'hffff, 1));
    for (int p = 0; p < len + 5; p++) begin
      if (p == cut) begin
        push_event(ACT_TIMEOUT, 8'($urandom_range(255)));
        return;
      end
      if (p == 0)
        d = big ? CODE_STX : CODE_SOH;
      else if (p == 1)
        d = num;
      else if (p == 2)
        d = num_ok ? ~num : ~num ^ 8'($urandom_range(255, 1));
      else if (p < len + 3) begin
        d = 8'($urandom_range(255));
        c = crc16_xmodem(c, d);
      end else if (p == len + 3)
        d = c[15:8] ^ flip[15:8];
      else
        d = c[7:0] ^ flip[7:0];
      push_event(ACT_BYTE, d);
    end
  endtask

  task automatic random_burst();
    int         sel;
    logic [7:0] num;
    sel = $urandom_range(99);
    num = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                   : 8'($urandom_range(255));
    if (sel < 50) begin
      send_block(1'b0, num, $urandom_range(99) < 85, $urandom_range(99) < 80,
                 ($urandom_range(99) < 12) ? int'($urandom_range(132)) : -1);
    end else if (sel < 58) begin
      push_event(ACT_BYTE, CODE_CA);
      push_event(ACT_BYTE, CODE_CA);
    end else if (sel < 63) begin
      push_event(ACT_BYTE, CODE_CA);
      push_event($urandom_range(3) == 0 ? ACT_TIMEOUT : ACT_BYTE, 8'($urandom_range(255)));
    end else if (sel < 68) begin
      push_event(ACT_BYTE, CODE_EOT);
    end else if (sel < 76) begin
      push_event(ACT_BYTE, $urandom_range(1) ? code_a : code_b);
    end else if (sel < 84) begin
      push_event(ACT_TIMEOUT, 8'($urandom_range(255)));
    end else begin
      push_event(ACT_BYTE, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = ACT_BYTE;
    m_tready      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ABORT_A;
    cfg_data      = '0;
    n_sent        = 0;
    quiet         = 0;
    src_idle_pct  = 25;
    sink_idle_pct = 76;
    code_a        = 8'd65;
    code_b        = 8'd97;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // start bytes with the reset abort codes
    push_event(ACT_BYTE, CODE_EOT);
    push_event(ACT_BYTE, code_a);
    push_event(ACT_BYTE, code_b);
    push_event(ACT_BYTE, 8'h00);
    push_event(ACT_BYTE, 8'hff);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_BYTE, CODE_SOH);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_TIMEOUT, 8'hff);
    push_event(ACT_TIMEOUT, 8'h00);
    push_event(ACT_BYTE, CODE_SOH);
    push_event(ACT_BYTE, 8'h05);
    push_event(ACT_TIMEOUT, 8'h00);
    push_event(ACT_BYTE, CODE_STX);
    push_event(ACT_BYTE, 8'h00);
    push_event(ACT_BYTE, 8'hff);
    push_event(ACT_TIMEOUT, 8'h55);

    // abort codes that collide with fixed codes lose
    set_codes(CODE_SOH, CODE_CA);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_BYTE, CODE_CA);
    push_event(ACT_BYTE, CODE_SOH);
    push_event(ACT_TIMEOUT, 8'h00);

    set_codes(8'h00, 8'hff);
    push_event(ACT_BYTE, 8'h00);
    push_event(ACT_BYTE, 8'hff);
    push_event(ACT_BYTE, 8'd65);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
        1: set_codes(CODE_EOT, CODE_STX);
        default: set_codes(8'hff, 8'hff);
      endcase
      src_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 76 : 0;
      sink_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 25 : 0;
      if (ph == 2)
        send_block(1'b1, 8'($urandom_range(255)), 1'b1, 1'b1, -1);
      for (int base = n_sent; n_sent < base + 170; )
        random_burst();
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && waiting == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/ymr_pkg.sv
hdl/ymr_cfg.sv
hdl/ymr_parser.sv
hdl/ymr_out_reg.sv
hdl/ymodem_packet_receiver.sv
bench/ymr_stream_checker.sv
bench/tb_ymodem_packet_receiver.sv
